>>> src/gpm_pkg.sv
`timescale 1ns / 1ps

package gpm_pkg;

   // Field and tap widths are fixed by the coefficient format
   localparam int COEF_W = 13;
   localparam int TAP_W  = 7;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_FIELD_POLY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_HIGH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_MID    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TAP_LOW    = 2'd3;

   localparam logic [COEF_W-1:0] FIELD_POLY_RST = 13'd27;
   localparam logic [TAP_W-1:0]  TAP_HIGH_RST   = 7'd10;
   localparam logic [TAP_W-1:0]  TAP_MID_RST    = 7'd9;
   localparam logic [TAP_W-1:0]  TAP_LOW_RST    = 7'd6;

   typedef logic [COEF_W-1:0] coef_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_MUL,
      ST_DRAIN,
      ST_FOLD,
      ST_EMIT
   } gpm_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic wr;         // store operand pair
      logic rd;         // fetch operand a coefficient
      logic clear;      // zero the accumulator
      logic fold;       // one reduction step
      logic shift_out;  // advance to next result pair
   } gpm_cmd_type;

   // Multiply by x modulo x^13 + poly
   function automatic coef_type gf_xtime(coef_type x, coef_type poly);
      coef_type r;
      r = {x[COEF_W-2:0], 1'b0};
      if (x[COEF_W-1]) r = r ^ poly;
      return r;
   endfunction

endpackage

>>> src/gf_poly_mul_mod_degree96.sv
`timescale 1ns / 1ps
// Polynomial multiplier over GF(2^13), reduced modulo
// x^DEGREE + x^tap_high + x^tap_mid + x^tap_low + 1.
// Input: pulse start with req_coef_a/req_coef_b while busy is low to transfer
// one coefficient pair, lowest index first; req_last marks the final pair.
// Pairs past DEGREE are dropped; indexes not loaded count as zero.
// Pairs load back to back. After the last pair, the block is busy: a multiply
// phase (one a coefficient times all b lanes per cycle through a row of
// DEGREE GF multipliers), a drain of the a_rd_ff and pw_ff pipeline registers
// and the fold phase, then (DEGREE+1)/2 result transfers on consecutive
// cycles, each marked by rsp_strobe for one cycle; rsp_final_res flags the
// last. The receiver cannot stall, so results leave at one pair per cycle.
// Configuration: csr_we/csr_index/csr_wdata; the user must write it only while idle, the block does not enforce this.
// Reset (synchronous) restores the default field polynomial (27) and taps
// (10, 9, 6) and empties the load count; operand storage is not cleared.

module gf_poly_mul_mod_degree96 #(
   parameter int DEGREE = 96
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [gpm_pkg::COEF_W-1:0]        req_coef_a,
   input  logic [gpm_pkg::COEF_W-1:0]        req_coef_b,
   input  logic                              req_last,
   output logic                              rsp_strobe,
   output logic [gpm_pkg::COEF_W-1:0]        rsp_coef_even,
   output logic [gpm_pkg::COEF_W-1:0]        rsp_coef_odd,
   output logic [5:0]                        rsp_pair_index,
   output logic                              rsp_final_res,
   input  logic                              csr_we,
   input  logic [gpm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [gpm_pkg::COEF_W-1:0]        csr_wdata
);

   localparam int AW = $clog2(DEGREE);
   localparam int NW = $clog2(DEGREE+1);

   gpm_pkg::gpm_cmd_type            cmd;
   logic [AW-1:0]                   wr_addr, rd_addr;
   logic [NW-1:0]                   n_count;
   logic [gpm_pkg::COEF_W-1:0]      field_poly_ff;
   logic [gpm_pkg::TAP_W-1:0]       tap_high_ff, tap_mid_ff, tap_low_ff;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         field_poly_ff <= gpm_pkg::FIELD_POLY_RST;
         tap_high_ff   <= gpm_pkg::TAP_HIGH_RST;
         tap_mid_ff    <= gpm_pkg::TAP_MID_RST;
         tap_low_ff    <= gpm_pkg::TAP_LOW_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            gpm_pkg::CSR_FIELD_POLY: field_poly_ff <= csr_wdata;
            gpm_pkg::CSR_TAP_HIGH:   tap_high_ff   <= csr_wdata[gpm_pkg::TAP_W-1:0];
            gpm_pkg::CSR_TAP_MID:    tap_mid_ff    <= csr_wdata[gpm_pkg::TAP_W-1:0];
            gpm_pkg::CSR_TAP_LOW:    tap_low_ff    <= csr_wdata[gpm_pkg::TAP_W-1:0];
            default: ;
         endcase
      end
   end

   gpm_ctrl #(.DEGREE(DEGREE)) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .req_last       (req_last),
      .busy           (busy),
      .cmd            (cmd),
      .wr_addr        (wr_addr),
      .rd_addr        (rd_addr),
      .n_count        (n_count),
      .rsp_strobe     (rsp_strobe),
      .rsp_pair_index (rsp_pair_index),
      .rsp_final_res  (rsp_final_res)
   );

   gpm_dpath #(.DEGREE(DEGREE)) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .wr_addr    (wr_addr),
      .rd_addr    (rd_addr),
      .n_count    (n_count),
      .coef_a     (req_coef_a),
      .coef_b     (req_coef_b),
      .field_poly (field_poly_ff),
      .tap_high   (tap_high_ff),
      .tap_mid    (tap_mid_ff),
      .tap_low    (tap_low_ff),
      .coef_even  (rsp_coef_even),
      .coef_odd   (rsp_coef_odd)
   );

endmodule

>>> src/gpm_ctrl.sv
`timescale 1ns / 1ps

module gpm_ctrl #(
   parameter int DEGREE = 96
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        req_last,
   output logic                        busy,
   output gpm_pkg::gpm_cmd_type        cmd,
   output logic [$clog2(DEGREE)-1:0]   wr_addr,
   output logic [$clog2(DEGREE)-1:0]   rd_addr,
   output logic [$clog2(DEGREE+1)-1:0] n_count,
   output logic                        rsp_strobe,
   output logic [5:0]                  rsp_pair_index,
   output logic                        rsp_final_res
);

   localparam int AW = $clog2(DEGREE);
   localparam int NW = $clog2(DEGREE+1);
   localparam int PAIRS = (DEGREE + 1) / 2;
   localparam logic [NW-1:0] DEG_N   = NW'(DEGREE);
   localparam logic [NW-1:0] FOLD_N  = NW'(DEGREE - 2);
   localparam logic [NW-1:0] LAST_PR = NW'(PAIRS - 1);
   localparam logic [NW-1:0] DRAIN_N = NW'(1);

   gpm_pkg::gpm_state_type state_ff, state_in;
   logic [NW-1:0] ld_ff, ld_in;
   logic [NW-1:0] cnt_ff, cnt_in;
   logic          accept;
   logic          room;
   logic [NW-1:0] ld_next;

   assign accept  = start && (state_ff == gpm_pkg::ST_LOAD);
   assign room    = (ld_ff < DEG_N);
   assign ld_next = room ? ld_ff + NW'(1) : ld_ff;

   // Next state and counters
   always_comb begin
      state_in = state_ff;
      ld_in    = ld_ff;
      cnt_in   = cnt_ff;
      unique case (state_ff)
         gpm_pkg::ST_LOAD: begin
            if (accept) begin
               ld_in = ld_next;
               if (req_last) begin
                  state_in = gpm_pkg::ST_MUL;
                  cnt_in   = ld_next - NW'(1);
               end
            end
         end
         gpm_pkg::ST_MUL: begin
            if (cnt_ff == '0) begin
               state_in = gpm_pkg::ST_DRAIN;
               cnt_in   = DRAIN_N;
            end else begin
               cnt_in = cnt_ff - NW'(1);
            end
         end
         gpm_pkg::ST_DRAIN: begin
            if (cnt_ff == '0) begin
               state_in = gpm_pkg::ST_FOLD;
               cnt_in   = FOLD_N;
            end else begin
               cnt_in = cnt_ff - NW'(1);
            end
         end
         gpm_pkg::ST_FOLD: begin
            if (cnt_ff == '0) begin
               state_in = gpm_pkg::ST_EMIT;
            end else begin
               cnt_in = cnt_ff - NW'(1);
            end
         end
         gpm_pkg::ST_EMIT: begin
            if (cnt_ff == LAST_PR) begin
               state_in = gpm_pkg::ST_LOAD;
               ld_in    = '0;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + NW'(1);
            end
         end
         default: begin
            state_in = gpm_pkg::ST_LOAD;
         end
      endcase
   end

   // Outputs
   always_comb begin
      cmd            = '0;
      busy           = 1'b1;
      rsp_strobe     = 1'b0;
      rsp_final_res  = 1'b0;
      unique case (state_ff)
         gpm_pkg::ST_LOAD: begin
            busy      = 1'b0;
            cmd.wr    = accept && room;
            cmd.clear = accept && req_last;
         end
         gpm_pkg::ST_MUL: begin
            cmd.rd = 1'b1;
         end
         gpm_pkg::ST_DRAIN: begin
            cmd.rd = 1'b0;
         end
         gpm_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
         end
         gpm_pkg::ST_EMIT: begin
            cmd.shift_out = 1'b1;
            rsp_strobe    = 1'b1;
            rsp_final_res = (cnt_ff == LAST_PR);
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   assign wr_addr        = ld_ff[AW-1:0];
   assign rd_addr        = cnt_ff[AW-1:0];
   assign n_count        = ld_ff;
   assign rsp_pair_index = 6'(cnt_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gpm_pkg::ST_LOAD;
         ld_ff    <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ld_ff    <= ld_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

>>> src/gpm_dpath.sv
`timescale 1ns / 1ps

module gpm_dpath #(
   parameter int DEGREE = 96
) (
   input  logic                          clock,
   input  logic                          reset,
   input  gpm_pkg::gpm_cmd_type          cmd,
   input  logic [$clog2(DEGREE)-1:0]     wr_addr,
   input  logic [$clog2(DEGREE)-1:0]     rd_addr,
   input  logic [$clog2(DEGREE+1)-1:0]   n_count,
   input  logic [gpm_pkg::COEF_W-1:0]    coef_a,
   input  logic [gpm_pkg::COEF_W-1:0]    coef_b,
   input  logic [gpm_pkg::COEF_W-1:0]    field_poly,
   input  logic [gpm_pkg::TAP_W-1:0]     tap_high,
   input  logic [gpm_pkg::TAP_W-1:0]     tap_mid,
   input  logic [gpm_pkg::TAP_W-1:0]     tap_low,
   output logic [gpm_pkg::COEF_W-1:0]    coef_even,
   output logic [gpm_pkg::COEF_W-1:0]    coef_odd
);

   localparam int CW = gpm_pkg::COEF_W;
   localparam int L  = 2 * DEGREE - 1;

   gpm_pkg::coef_type a_mem [DEGREE];
   gpm_pkg::coef_type b_ff [DEGREE];
   gpm_pkg::coef_type acc_ff [L];
   gpm_pkg::coef_type acc_in [L];
   gpm_pkg::coef_type pw_ff [CW];
   gpm_pkg::coef_type pw_in [CW];
   gpm_pkg::coef_type lane_prod [DEGREE];
   gpm_pkg::coef_type a_rd_ff;
   gpm_pkg::coef_type fold_v;
   logic v1_ff, v2_ff;

   // Odd number of reduction terms landing on position m (a pre-shift index counted from the bottom)
   function automatic logic fold_hit(int m, logic [gpm_pkg::TAP_W-1:0] th,
                                     logic [gpm_pkg::TAP_W-1:0] tm,
                                     logic [gpm_pkg::TAP_W-1:0] tl);
      logic h;
      h = (m == DEGREE - 2);
      if (int'(th) < DEGREE && m == DEGREE - 2 + int'(th)) h = !h;
      if (int'(tm) < DEGREE && m == DEGREE - 2 + int'(tm)) h = !h;
      if (int'(tl) < DEGREE && m == DEGREE - 2 + int'(tl)) h = !h;
      return h;
   endfunction

   // Operand a memory, one read port
   always_ff @(posedge clock) begin
      if (cmd.wr) a_mem[wr_addr] <= coef_a;
      if (cmd.rd) a_rd_ff <= a_mem[rd_addr];
   end

   // Operand b lanes
   always_ff @(posedge clock) begin
      for (int j = 0; j < DEGREE; j++) begin
         if (cmd.wr && int'(wr_addr) == j) b_ff[j] <= coef_b;
      end
   end

   // x^k multiples of the fetched a coefficient
   always_comb begin
      pw_in[0] = a_rd_ff;
      for (int k = 1; k < CW; k++) begin
         pw_in[k] = gpm_pkg::gf_xtime(pw_in[k-1], field_poly);
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff) pw_ff <= pw_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.rd;
         v2_ff <= v1_ff;
      end
   end

   // One GF multiplier per b lane; lanes past the loaded count are zero
   always_comb begin
      for (int j = 0; j < DEGREE; j++) begin
         lane_prod[j] = '0;
         if (j < int'(n_count)) begin
            for (int k = 0; k < CW; k++) begin
               if (b_ff[j][k]) lane_prod[j] = lane_prod[j] ^ pw_ff[k];
            end
         end
      end
   end

   assign fold_v = acc_ff[L-1];

   // Accumulator: clear, Horner step, fold step, or result shift
   always_comb begin
      for (int m = 0; m < L; m++) acc_in[m] = acc_ff[m];
      if (cmd.clear) begin
         for (int m = 0; m < L; m++) acc_in[m] = '0;
      end else if (v2_ff) begin
         for (int m = 0; m < L; m++) begin
            acc_in[m] = (m > 0) ? acc_ff[(m > 0) ? m - 1 : 0] : '0;
            if (m < DEGREE) acc_in[m] = acc_in[m] ^ lane_prod[(m < DEGREE) ? m : 0];
         end
      end else if (cmd.fold) begin
         acc_in[0] = '0;
         for (int m = 1; m < L; m++) begin
            acc_in[m] = acc_ff[m-1];
            if (fold_hit(m - 1, tap_high, tap_mid, tap_low))
               acc_in[m] = acc_in[m] ^ fold_v;
         end
      end else if (cmd.shift_out) begin
         for (int m = 0; m < L; m++) begin
            acc_in[m] = (m + 2 < L) ? acc_ff[(m + 2 < L) ? m + 2 : 0] : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Result coefficient k sits at position DEGREE-1+k after folding
   assign coef_even = acc_ff[DEGREE-1];
   assign coef_odd  = acc_ff[DEGREE];

endmodule

>>> tb/gf_poly_mul_mod_degree96_tb.sv
`timescale 1ns / 1ps

module gf_poly_mul_mod_degree96_tb;

   localparam int DEG      = 96;
   localparam int PROD_N   = 2 * DEG - 1;
   localparam int N_PAIRS  = DEG / 2;
   localparam int SETTLE   = 400;

   typedef struct {
      gpm_pkg::coef_type a;
      gpm_pkg::coef_type b;
      logic              last;
   } coef_pair_type;

   typedef struct {
      gpm_pkg::coef_type even;
      gpm_pkg::coef_type odd;
      logic [5:0]        idx;
      logic              fin;
   } res_pair_type;

   logic                          clock;
   logic                          reset;
   logic                          start;
   logic                          busy;
   gpm_pkg::coef_type             req_coef_a;
   gpm_pkg::coef_type             req_coef_b;
   logic                          req_last;
   logic                          rsp_strobe;
   gpm_pkg::coef_type             rsp_coef_even;
   gpm_pkg::coef_type             rsp_coef_odd;
   logic [5:0]                    rsp_pair_index;
   logic                          rsp_final_res;
   logic                          csr_we;
   logic [gpm_pkg::CSR_IDX_W-1:0] csr_index;
   gpm_pkg::coef_type             csr_wdata;

   gf_poly_mul_mod_degree96 dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_coef_a(req_coef_a), .req_coef_b(req_coef_b), .req_last(req_last),
      .rsp_strobe(rsp_strobe), .rsp_coef_even(rsp_coef_even),
      .rsp_coef_odd(rsp_coef_odd), .rsp_pair_index(rsp_pair_index),
      .rsp_final_res(rsp_final_res), .csr_we(csr_we), .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Shadow state of the multiplier
   gpm_pkg::coef_type poly_sh;
   logic [6:0]        tap_sh [3];
   gpm_pkg::coef_type op_a [DEG];
   gpm_pkg::coef_type op_b [DEG];
   int unsigned       loaded;

   coef_pair_type pending_pairs [$];
   res_pair_type  expected_res [$];
   coef_pair_type cur_pair;
   int            burst_left;
   int            gap_left;
   int            errors;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // GF(2^13) multiply, high bit of y first
   function automatic gpm_pkg::coef_type gf13_mul(gpm_pkg::coef_type x,
                                                  gpm_pkg::coef_type y,
                                                  gpm_pkg::coef_type poly);
      logic [13:0] r;
      r = '0;
      for (int k = 12; k >= 0; k--) begin
         r = r << 1;
         if (r[13]) r = r ^ {1'b1, poly};
         if (y[k]) r = r ^ {1'b0, x};
      end
      return r[12:0];
   endfunction

   // Load one pair; on last, compute and queue the 48 reduced pairs
   task automatic predict_product(coef_pair_type p);
      gpm_pkg::coef_type prod [PROD_N];
      gpm_pkg::coef_type v;
      if (loaded < DEG) begin
         op_a[loaded] = p.a;
         op_b[loaded] = p.b;
         loaded++;
      end
      if (p.last) begin
         foreach (prod[k]) prod[k] = '0;
         for (int i = 0; i < loaded; i++)
            for (int j = 0; j < loaded; j++)
               prod[i+j] ^= gf13_mul(op_a[i], op_b[j], poly_sh);
         // fold top down so refolded terms get caught
         for (int i = PROD_N - 1; i >= DEG; i--) begin
            v = prod[i];
            for (int t = 0; t < 3; t++)
               if (tap_sh[t] < DEG) prod[i - DEG + tap_sh[t]] ^= v;
            prod[i - DEG] ^= v;
         end
         for (int i = 0; i < N_PAIRS; i++)
            expected_res.push_back('{prod[2*i], prod[2*i+1], i[5:0], i == N_PAIRS - 1});
         loaded = 0;
      end
   endtask

   // Driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start      <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else if (!(start && busy)) begin
         if (start) begin
            predict_product(cur_pair);
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 24);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_pairs.size() > 0) begin
            cur_pair = pending_pairs.pop_front();
            req_coef_a <= cur_pair.a;
            req_coef_b <= cur_pair.b;
            req_last   <= cur_pair.last;
            start      <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe must match the oldest expected pair
   always @(posedge clock) begin
      res_pair_type e;
      if (!reset && rsp_strobe) begin
         if (expected_res.size() == 0) begin
            $error("unexpected result transfer, pair_index %0d", rsp_pair_index);
            errors++;
         end else begin
            e = expected_res.pop_front();
            if (rsp_coef_even !== e.even) begin
               $error("coef_even: expected %0d, got %0d", e.even, rsp_coef_even);
               errors++;
            end
            if (rsp_coef_odd !== e.odd) begin
               $error("coef_odd: expected %0d, got %0d", e.odd, rsp_coef_odd);
               errors++;
            end
            if (rsp_pair_index !== e.idx) begin
               $error("pair_index: expected %0d, got %0d", e.idx, rsp_pair_index);
               errors++;
            end
            if (rsp_final_res !== e.fin) begin
               $error("final_res: expected %0d, got %0d", e.fin, rsp_final_res);
               errors++;
            end
         end
      end
   end

   task automatic add_pair(gpm_pkg::coef_type a, gpm_pkg::coef_type b, logic last);
      pending_pairs.push_back('{a, b, last});
   endtask

   // n random pairs, last marked on the final one
   task automatic add_operands(int n);
      for (int k = 0; k < n; k++)
         add_pair(13'($urandom_range(0, 8191)), 13'($urandom_range(0, 8191)),
                  k == n - 1);
   endtask

   task automatic add_short_products(int count);
      for (int k = 0; k < count; k++)
         add_operands(($urandom_range(0, 5) == 0) ? $urandom_range(25, 96)
                                                  : $urandom_range(1, 12));
   endtask

   // Wait until every transfer is done and the block has gone quiet
   task automatic drain();
      while (pending_pairs.size() > 0 || start || expected_res.size() > 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic csr_write(logic [gpm_pkg::CSR_IDX_W-1:0] idx, gpm_pkg::coef_type val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == gpm_pkg::CSR_FIELD_POLY) poly_sh = val;
      else if (idx == gpm_pkg::CSR_TAP_HIGH) tap_sh[0] = val[6:0];
      else if (idx == gpm_pkg::CSR_TAP_MID) tap_sh[1] = val[6:0];
      else tap_sh[2] = val[6:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_config(gpm_pkg::coef_type poly, logic [6:0] th, logic [6:0] tm,
                             logic [6:0] tl);
      csr_write(gpm_pkg::CSR_FIELD_POLY, poly);
      csr_write(gpm_pkg::CSR_TAP_HIGH, {6'd0, th});
      csr_write(gpm_pkg::CSR_TAP_MID, {6'd0, tm});
      csr_write(gpm_pkg::CSR_TAP_LOW, {6'd0, tl});
   endtask

   // Stimulus and phase sequencing
   initial begin
      errors     = 0;
      loaded     = 0;
      poly_sh    = gpm_pkg::FIELD_POLY_RST;
      tap_sh[0]  = gpm_pkg::TAP_HIGH_RST;
      tap_sh[1]  = gpm_pkg::TAP_MID_RST;
      tap_sh[2]  = gpm_pkg::TAP_LOW_RST;
      reset      = 1'b1;
      start      = 1'b0;
      req_coef_a = '0;
      req_coef_b = '0;
      req_last   = 1'b0;
      csr_we     = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, early last, zero operands
      add_pair(13'h1FFF, 13'h1FFF, 1'b1);
      add_pair(13'h0000, 13'h1FFF, 1'b1);
      add_pair(13'h0001, 13'h1000, 1'b0);
      add_pair(13'h1000, 13'h0001, 1'b1);
      add_pair(13'h0AAA, 13'h1555, 1'b0);
      add_pair(13'h1555, 13'h0AAA, 1'b0);
      add_pair(13'h1FFF, 13'h0000, 1'b1);
      add_short_products(2);
      drain();

      // all taps dropped, full field poly, long product
      set_config(13'h1FFF, 7'd127, 7'd127, 7'd127);
      add_operands(30);
      drain();

      // zero poly, all taps at zero cancel in pairs
      set_config(13'h0000, 7'd0, 7'd0, 7'd0);
      add_short_products(2);
      drain();

      // taps straddling the degree; overflow past 96 pairs
      set_config(13'($urandom_range(0, 8191)), 7'd95, 7'd96, 7'd1);
      add_operands(98);
      drain();

      // repeated taps
      set_config(13'($urandom_range(0, 8191)), 7'd5, 7'd5, 7'd64);
      add_short_products(1);
      drain();

      // random settings
      set_config(13'($urandom_range(0, 8191)), 7'($urandom_range(0, 127)),
                 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
      add_short_products(1);
      drain();

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
